FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while reset is low.
`define CMA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Types and constants of the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int MAX_RADIUS_DEF  = 31;
   localparam int RING_DEPTH_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int REQ_SAMPLE_BITS = 16;
   localparam int REQ_DATA_BITS   = 16;
   localparam int K_BITS          = 5;
   localparam int WIN_BITS        = K_BITS + 1;
   localparam int AVG_BITS        = 17;
   localparam int RSP_DATA_BITS   = 24;

   localparam logic [K_BITS-1:0]   RADIUS_RESET = K_BITS'(1);
   localparam logic [AVG_BITS-1:0] AVG_NONE     = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_EMIT
   } cma_state_type;

endpackage

FILE: rtl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div
   import cma_pkg::*;
#(
   parameter int DIVIDEND_BITS = 22,
   parameter int DIVISOR_BITS  = WIN_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVISOR_BITS:0]    rem_shift;
   logic [DIVISOR_BITS:0]    rem_sub;
   logic                     bit_ge;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
      bit_ge    = rem_shift >= {1'b0, div_ff};
      rem_sub   = rem_shift - {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quot_in   = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         rem_in  = '0;
         div_in  = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         rem_in  = bit_ge ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
         quot_in = {quot_ff[DIVIDEND_BITS-2:0], bit_ge};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/centered_moving_average_top.sv
// A complete-window average passes the ring read, the sum update, the bit-serial
// divide and the output register before it leaves.
// Requests are taken one at a time, only in the idle state: a new one waits until
// every result of the previous one has been written to the output register (up to
// radius+1 results on a last).
// Reset: synchronous, clears control, sum, count and pointer; radius returns to 1.
// ----------------------------------------------------------------------------
// centered_moving_average_top
// Centered odd-window moving average over a sample stream with last marker.
// The sample ring is not cleared; only slots written in the current run are used.
// ----------------------------------------------------------------------------
module centered_moving_average_top
   import cma_pkg::*;
#(
   parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [K_BITS-1:0]        csr_wdata,      // radius
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,      // [15:0] sample
   input  logic                     req_tlast,      // is_last
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,      // [16:0] average, rest zero
   output logic                     rsp_tlast       // last_result
);

   localparam int K_CAP_A  = (RING_DEPTH - 1) / 2;
   localparam int K_CAP    = (MAX_RADIUS < K_CAP_A) ? MAX_RADIUS : K_CAP_A;
   localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
   localparam int PTR_BITS = $clog2(RING_DEPTH);
   localparam int CNT_BITS = $clog2(RING_DEPTH + 1);

   cma_state_type state_ff, state_in;

   logic [K_BITS-1:0]      radius_ff, radius_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [PTR_BITS-1:0]    wptr_ff, wptr_in;
   logic [SAMPLE_BITS-1:0] s_ff, s_in;
   logic                   last_ff, last_in;
   logic [CNT_BITS-1:0]    p_ff, p_in;
   logic                   have_main_ff, have_main_in;
   logic [AVG_BITS-1:0]    main_ff, main_in;
   logic [K_BITS-1:0]      flush_ff, flush_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AVG_BITS-1:0]    rsp_avg_ff, rsp_avg_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   logic [K_BITS-1:0]      k_eff;
   logic [WIN_BITS-1:0]    win;
   logic [PTR_BITS-1:0]    rd_addr;
   logic [SUM_BITS-1:0]    sum_new;
   logic                   req_fire;
   logic                   rsp_free;
   logic                   div_start;
   logic                   div_done;
   logic [SUM_BITS-1:0]    div_quot;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign k_eff    = (32'(radius_ff) > K_CAP) ? K_BITS'(K_CAP) : radius_ff;
   assign win      = {k_eff, 1'b1};
   assign rd_addr  = (32'(wptr_ff) >= 32'(win)) ?
                     PTR_BITS'(32'(wptr_ff) - 32'(win)) :
                     PTR_BITS'(32'(wptr_ff) + RING_DEPTH - 32'(win));
   assign sum_new  = sum_ff + SUM_BITS'(s_ff)
                     - ((32'(p_ff) >= 32'(win)) ? SUM_BITS'(rdata_ff) : SUM_BITS'(0));

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      wptr_in      = wptr_ff;
      s_in         = s_ff;
      last_in      = last_ff;
      p_in         = p_ff;
      have_main_in = have_main_ff;
      main_in      = main_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               radius_in = csr_wdata;
               sum_in    = '0;
               count_in  = '0;
               wptr_in   = '0;
            end else if (req_fire) begin
               s_in     = SAMPLE_BITS'(req_tdata[REQ_SAMPLE_BITS-1:0]);
               last_in  = req_tlast;
               p_in     = count_ff;
               wptr_in  = (32'(wptr_ff) == RING_DEPTH - 1) ? '0 : wptr_ff + PTR_BITS'(1);
               count_in = (32'(count_ff) == RING_DEPTH) ? count_ff
                                                        : count_ff + CNT_BITS'(1);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in       = last_ff ? '0 : sum_new;
            have_main_in = 32'(p_ff) >= 32'(k_eff);
            main_in      = AVG_NONE;
            if (!last_ff)
               flush_in = '0;
            else if (32'(k_eff) < 32'(p_ff) + 1)
               flush_in = k_eff;
            else
               flush_in = K_BITS'(32'(p_ff) + 1);
            if (32'(p_ff) >= 2 * 32'(k_eff)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (have_main_in || flush_in != '0) begin
               state_in = ST_EMIT;
            end else begin
               if (last_ff) begin
                  count_in = '0;
                  wptr_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               main_in  = AVG_BITS'(div_quot);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (have_main_ff) begin
                  rsp_avg_in   = main_ff;
                  rsp_last_in  = last_ff && (flush_ff == '0);
                  have_main_in = 1'b0;
               end else begin
                  rsp_avg_in  = AVG_NONE;
                  rsp_last_in = last_ff && (flush_ff == K_BITS'(1));
                  flush_in    = flush_ff - K_BITS'(1);
               end
               if ((have_main_ff && flush_ff == '0) ||
                   (!have_main_ff && flush_ff == K_BITS'(1))) begin
                  if (last_ff) begin
                     count_in = '0;
                     wptr_in  = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         wptr_ff      <= '0;
         have_main_ff <= 1'b0;
         flush_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         wptr_ff      <= wptr_in;
         have_main_ff <= have_main_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff        <= s_in;
      last_ff     <= last_in;
      p_ff        <= p_in;
      main_ff     <= main_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_last_ff <= rsp_last_in;
   end

   // sample ring: write new sample, read the one leaving the window
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ring[wptr_ff] <= SAMPLE_BITS'(req_tdata[REQ_SAMPLE_BITS-1:0]);
         rdata_ff      <= ring[rd_addr];
      end
   end

   cma_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (WIN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (win),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_avg_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/cma_checker.sv
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks of the centered moving average block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cma_checker
   import cma_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   `CMA_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response changed while stalled")

   `CMA_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "response valid after reset")

   `CMA_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while one is in work")

   `CMA_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:AVG_BITS] == '0, "response padding not zero")

endmodule

bind centered_moving_average_top cma_checker u_cma_checker (.*);
